@@ src/canonical_kmer_stream_macros.svh @@
// assertion macros for the checker file
`ifndef CANONICAL_KMER_STREAM_MACROS_SVH
`define CANONICAL_KMER_STREAM_MACROS_SVH

// property holds on every rising clock edge outside reset
`define CKS_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CKS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/ckmer_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckmer_pkg
// shared types, character codes and window helpers for the k-mer extractor
// ----------------------------------------------------------------------------
package ckmer_pkg;

	localparam int MAX_K  = 32;
	localparam int KSZ_W  = 6;
	localparam int CHAR_W = 8;
	localparam int WIN_W  = 2 * MAX_K;
	localparam int SH_W   = KSZ_W + 1;

	typedef logic [KSZ_W-1:0]  ksize_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [WIN_W-1:0]  window_t;
	typedef logic [1:0]        base_code_t;

	localparam char_t CHAR_A = 8'h41;
	localparam char_t CHAR_C = 8'h43;
	localparam char_t CHAR_G = 8'h47;
	localparam char_t CHAR_T = 8'h54;

	localparam base_code_t CODE_C = 2'd0;
	localparam base_code_t CODE_A = 2'd1;
	localparam base_code_t CODE_T = 2'd2;
	localparam base_code_t CODE_G = 2'd3;

	localparam ksize_t KSIZE_RESET = ksize_t'(MAX_K);

	typedef struct packed {
		char_t base_char;
		logic  read_start;
	} in_beat_t;

	function automatic ksize_t eff_k(input ksize_t k);
		ksize_t r;
		r = k;
		if (k == '0)
			r = ksize_t'(1);
		else if (k > ksize_t'(MAX_K))
			r = ksize_t'(MAX_K);
		return r;
	endfunction

	function automatic window_t window_mask(input ksize_t k);
		window_t m;
		if (k >= ksize_t'(MAX_K))
			m = '1;
		else
			m = (window_t'(1) << {k, 1'b0}) - window_t'(1);
		return m;
	endfunction

endpackage

@@ src/ckmer_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckmer channel interfaces
// valid/ready channels for read characters, k-mer results and configuration
// ----------------------------------------------------------------------------
interface ckmer_in_if;
	import ckmer_pkg::*;
	logic  valid;
	logic  ready;
	char_t base_char;
	logic  read_start;
	modport source (output valid, base_char, read_start, input ready);
	modport sink (input valid, base_char, read_start, output ready);
endinterface

interface ckmer_out_if;
	import ckmer_pkg::*;
	logic    valid;
	logic    ready;
	window_t canonical_kmer;
	modport source (output valid, canonical_kmer, input ready);
	modport sink (input valid, canonical_kmer, output ready);
endinterface

interface ckmer_cfg_if;
	import ckmer_pkg::*;
	logic   valid;
	logic   ready;
	ksize_t k_len;
	modport source (output valid, k_len, input ready);
	modport sink (input valid, k_len, output ready);
endinterface

@@ src/ckmer_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckmer_in_stage
// input register for read characters, refilled in the cycle it drains
// ----------------------------------------------------------------------------
module ckmer_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	ckmer_in_if.sink           bases,
	input  logic               take,
	output logic               valid_s1,
	output ckmer_pkg::in_beat_t beat_s1
);
	import ckmer_pkg::*;

	logic load;

	assign bases.ready = !valid_s1 || take;
	assign load        = bases.valid && bases.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bases.ready) begin
			valid_s1 <= bases.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_s1.base_char  <= bases.base_char;
			beat_s1.read_start <= bases.read_start;
		end
	end

endmodule

@@ src/ckmer_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckmer_window
// rolling forward and reverse-complement windows with canonical result register
// ----------------------------------------------------------------------------
module ckmer_window (
	input  logic                clk,
	input  logic                arst_n,
	input  ckmer_pkg::ksize_t   k_len,
	input  logic                beat_valid,
	input  ckmer_pkg::in_beat_t beat,
	output logic                take,
	ckmer_out_if.source         kmers
);
	import ckmer_pkg::*;

	window_t    fwd_q, rev_q;
	ksize_t     count_q;
	logic       out_valid_q;
	window_t    out_data_q;

	ksize_t     k;
	window_t    mask;
	logic       is_base;
	base_code_t code;
	window_t    fwd_base, rev_base, fwd_n, rev_n, result;
	ksize_t     cnt_base, cnt_inc, cnt_n;
	logic [SH_W-1:0] top_sh;
	logic       produce;
	logic       adv;

	assign take = !out_valid_q || kmers.ready;
	assign adv  = beat_valid && take;

	always_comb begin
		is_base = 1'b1;
		code    = CODE_C;
		case (beat.base_char)
			CHAR_C:  code = CODE_C;
			CHAR_A:  code = CODE_A;
			CHAR_T:  code = CODE_T;
			CHAR_G:  code = CODE_G;
			default: is_base = 1'b0;
		endcase
	end

	always_comb begin
		k        = eff_k(k_len);
		mask     = window_mask(k);
		top_sh   = {k, 1'b0} - SH_W'(2);
		fwd_base = beat.read_start ? '0 : fwd_q;
		rev_base = beat.read_start ? '0 : rev_q;
		cnt_base = beat.read_start ? '0 : count_q;
		fwd_n    = ((fwd_base << 2) | WIN_W'(code)) & mask;
		rev_n    = (((rev_base & mask) >> 2) | (WIN_W'(2'd3 - code) << top_sh)) & mask;
		cnt_inc  = (cnt_base < k) ? cnt_base + ksize_t'(1) : cnt_base;
		cnt_n    = (cnt_inc > k) ? k : cnt_inc;
		produce  = is_base && (cnt_n == k);
		result   = (fwd_n >= rev_n) ? fwd_n : rev_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q   <= '0;
			rev_q   <= '0;
			count_q <= '0;
		end else if (adv) begin
			if (is_base) begin
				fwd_q   <= fwd_n;
				rev_q   <= rev_n;
				count_q <= cnt_n;
			end else begin
				fwd_q   <= '0;
				rev_q   <= '0;
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= adv && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && produce) begin
			out_data_q <= result;
		end
	end

	assign kmers.valid          = out_valid_q;
	assign kmers.canonical_kmer = out_data_q;

endmodule

@@ src/canonical_kmer_stream.sv @@
// path: a character beat is accepted into the input register, and its k-mer
// is then registered in the result register, where the sink can take it
// throughput: one character beat per cycle, stalls only while the result
// register holds an untaken k-mer
// reset: arst_n clears both windows, the base count and the valid flags,
// and sets the k-mer length to 32
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_kmer_stream
// canonical 2-bit k-mer extractor over a stream of read characters
// ----------------------------------------------------------------------------
module canonical_kmer_stream (
	input  logic        clk,
	input  logic        arst_n,
	ckmer_cfg_if.sink   cfg,
	ckmer_in_if.sink    bases,
	ckmer_out_if.source kmers
);
	import ckmer_pkg::*;

	ksize_t   k_len_q;
	logic     valid_s1;
	in_beat_t beat_s1;
	logic     take;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_len_q <= KSIZE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			k_len_q <= cfg.k_len;
		end
	end

	ckmer_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.bases    (bases),
		.take     (take),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	ckmer_window u_win (
		.clk        (clk),
		.arst_n     (arst_n),
		.k_len      (k_len_q),
		.beat_valid (valid_s1),
		.beat       (beat_s1),
		.take       (take),
		.kmers      (kmers)
	);

endmodule

@@ src/ckmer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckmer_checker
// port-level checks of the k-mer extractor, bound to the top level
// ----------------------------------------------------------------------------
`include "canonical_kmer_stream_macros.svh"

module ckmer_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                bases_valid,
	input logic                bases_ready,
	input logic                kmers_valid,
	input logic                kmers_ready,
	input ckmer_pkg::window_t  kmers_data
);
	import ckmer_pkg::*;

	`CKS_ASSERT_NEXT(a_out_hold, clk, arst_n, kmers_valid && !kmers_ready, kmers_valid, "stalled result beat dropped")
	`CKS_ASSERT_NEXT(a_out_stable, clk, arst_n, kmers_valid && !kmers_ready, $stable(kmers_data), "stalled result beat changed")
	`CKS_ASSERT(a_ready_when_empty, clk, arst_n, !kmers_valid |-> bases_ready, "input stalled with empty result register")
	`CKS_ASSERT(a_result_has_source, clk, arst_n, $rose(kmers_valid) |-> $past(bases_valid && bases_ready, 2), "result without a character beat")

endmodule

bind canonical_kmer_stream ckmer_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.bases_valid (bases.valid),
	.bases_ready (bases.ready),
	.kmers_valid (kmers.valid),
	.kmers_ready (kmers.ready),
	.kmers_data  (kmers.canonical_kmer)
);
